FILE: rtl/krpc_pkg.sv
// ----------------------------------------------------------------------------
// krpc_pkg
// Shared types and constants for the robust kinship pair counter.
// ----------------------------------------------------------------------------
package krpc_pkg;

    // One request carries this many loci per bit plane
    localparam int ITEM_BITS = 64;
    // Loci handled by each lane
    localparam int LANE_BITS = 8;
    localparam int NUM_LANES = ITEM_BITS / LANE_BITS;
    // Per-lane count width (0 .. LANE_BITS)
    localparam int LANE_CW   = $clog2(LANE_BITS + 1);
    // Per-word total width (0 .. ITEM_BITS)
    localparam int TOT_W     = $clog2(ITEM_BITS + 1);
    // Per-word het + 4*IBS0 width
    localparam int DIST_W    = $clog2(4 * ITEM_BITS + 1);
    // Accumulator and result width
    localparam int ACC_W     = 32;

    // Counts found by one lane in one word
    typedef struct packed {
        logic [LANE_CW-1:0] loci;
        logic [LANE_CW-1:0] ibs0;
        logic [LANE_CW-1:0] het;
        logic [LANE_CW-1:0] i_het;
        logic [LANE_CW-1:0] j_het;
    } lane_cnt_t;

    // Control from the lane stage into the merge stage
    typedef struct packed {
        logic fire;
        logic last;
    } merge_ctl_t;

endpackage

FILE: rtl/krpc_lane.sv
// ----------------------------------------------------------------------------
// krpc_lane
// Classifies one slice of loci and registers the slice's popcounts.
// ----------------------------------------------------------------------------
module krpc_lane
    import krpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  logic [LANE_BITS-1:0] i_low,
    input  logic [LANE_BITS-1:0] i_high,
    input  logic [LANE_BITS-1:0] j_low,
    input  logic [LANE_BITS-1:0] j_high,
    input  logic [LANE_BITS-1:0] mask,
    output lane_cnt_t            cnt
);

    logic [LANE_BITS-1:0] present;
    logic [LANE_BITS-1:0] diff_low;
    logic [LANE_BITS-1:0] diff_high;
    lane_cnt_t            cnt_next;
    lane_cnt_t            cnt_reg;

    // Per-locus classification; missing is low=0, high=1
    assign present   = (i_low | ~i_high) & (j_low | ~j_high) & mask;
    assign diff_low  = i_low ^ j_low;
    assign diff_high = i_high ^ j_high;

    // Slice popcounts
    always_comb
    begin
        cnt_next = '0;
        for (int b = 0; b < LANE_BITS; b++)
        begin
            cnt_next.loci  = cnt_next.loci  + LANE_CW'(present[b]);
            cnt_next.ibs0  = cnt_next.ibs0
                           + LANE_CW'(diff_low[b] & diff_high[b] & present[b]);
            cnt_next.het   = cnt_next.het
                           + LANE_CW'((diff_low[b] ^ diff_high[b]) & present[b]);
            cnt_next.i_het = cnt_next.i_het
                           + LANE_CW'(i_low[b] & ~i_high[b] & present[b]);
            cnt_next.j_het = cnt_next.j_het
                           + LANE_CW'(j_low[b] & ~j_high[b] & present[b]);
        end
    end

    // Counts held until the merge stage takes them
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

FILE: rtl/krpc_merge.sv
// ----------------------------------------------------------------------------
// krpc_merge
// Sums the lane counts, keeps the running totals and holds the result.
// ----------------------------------------------------------------------------
module krpc_merge
    import krpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_cnt_t        lane_cnt [NUM_LANES],
    input  merge_ctl_t       ctl,
    input  logic             result_ready,
    output logic             result_valid,
    output logic             result_busy,
    output logic [ACC_W-1:0] valid_loci,
    output logic [ACC_W-1:0] opposite_homozygous,
    output logic [ACC_W-1:0] distance_sum,
    output logic [ACC_W-1:0] i_heterozygous,
    output logic [ACC_W-1:0] j_heterozygous
);

    logic [TOT_W-1:0]  sum_loci;
    logic [TOT_W-1:0]  sum_ibs0;
    logic [TOT_W-1:0]  sum_het;
    logic [TOT_W-1:0]  sum_i_het;
    logic [TOT_W-1:0]  sum_j_het;
    logic [DIST_W-1:0] sum_dist;

    logic [ACC_W-1:0]  acc_loci_reg,  acc_loci_next;
    logic [ACC_W-1:0]  acc_ibs0_reg,  acc_ibs0_next;
    logic [ACC_W-1:0]  acc_dist_reg,  acc_dist_next;
    logic [ACC_W-1:0]  acc_i_het_reg, acc_i_het_next;
    logic [ACC_W-1:0]  acc_j_het_reg, acc_j_het_next;

    logic              result_valid_reg;
    logic [ACC_W-1:0]  loci_reg, ibs0_reg, dist_reg, i_het_reg, j_het_reg;

    // Reduce lane counts to word totals
    always_comb
    begin
        sum_loci  = '0;
        sum_ibs0  = '0;
        sum_het   = '0;
        sum_i_het = '0;
        sum_j_het = '0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            sum_loci  = sum_loci  + TOT_W'(lane_cnt[l].loci);
            sum_ibs0  = sum_ibs0  + TOT_W'(lane_cnt[l].ibs0);
            sum_het   = sum_het   + TOT_W'(lane_cnt[l].het);
            sum_i_het = sum_i_het + TOT_W'(lane_cnt[l].i_het);
            sum_j_het = sum_j_het + TOT_W'(lane_cnt[l].j_het);
        end
        sum_dist = DIST_W'(sum_het) + (DIST_W'(sum_ibs0) << 2);
    end

    // Running totals including this word, wrapping at 2^32
    assign acc_loci_next  = acc_loci_reg  + ACC_W'(sum_loci);
    assign acc_ibs0_next  = acc_ibs0_reg  + ACC_W'(sum_ibs0);
    assign acc_dist_next  = acc_dist_reg  + ACC_W'(sum_dist);
    assign acc_i_het_next = acc_i_het_reg + ACC_W'(sum_i_het);
    assign acc_j_het_next = acc_j_het_reg + ACC_W'(sum_j_het);

    // Accumulators: cleared once the last word's totals are captured
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_loci_reg     <= '0;
            acc_ibs0_reg     <= '0;
            acc_dist_reg     <= '0;
            acc_i_het_reg    <= '0;
            acc_j_het_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.fire)
            begin
                if (ctl.last)
                begin
                    acc_loci_reg  <= '0;
                    acc_ibs0_reg  <= '0;
                    acc_dist_reg  <= '0;
                    acc_i_het_reg <= '0;
                    acc_j_het_reg <= '0;
                end
                else
                begin
                    acc_loci_reg  <= acc_loci_next;
                    acc_ibs0_reg  <= acc_ibs0_next;
                    acc_dist_reg  <= acc_dist_next;
                    acc_i_het_reg <= acc_i_het_next;
                    acc_j_het_reg <= acc_j_het_next;
                end
            end
            // Result slot
            if (ctl.fire && ctl.last)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctl.fire && ctl.last)
        begin
            loci_reg  <= acc_loci_next;
            ibs0_reg  <= acc_ibs0_next;
            dist_reg  <= acc_dist_next;
            i_het_reg <= acc_i_het_next;
            j_het_reg <= acc_j_het_next;
        end
    end

    assign result_valid        = result_valid_reg;
    assign result_busy         = result_valid_reg & ~result_ready;
    assign valid_loci          = loci_reg;
    assign opposite_homozygous = ibs0_reg;
    assign distance_sum        = dist_reg;
    assign i_heterozygous      = i_het_reg;
    assign j_heterozygous      = j_het_reg;

endmodule

FILE: rtl/king_robust_pair_counter.sv
// ----------------------------------------------------------------------------
// king_robust_pair_counter
// Counts valid loci, IBS0 and heterozygote loci, and the het + 4*IBS0 sum, for
// one pair of individuals over a stream of packed genotype words.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+--------------------------------
//   word    | word_valid / word_ready     | i/j low and high planes, last
//   result  | result_valid / result_ready | five 32-bit totals
//
// One word per cycle sustained while no last word waits on the result slot;
// a word's totals pass the lane popcount register, then the merge and result
// register. Eight lanes of eight loci count in parallel; the merge adds the
// word totals into 32-bit accumulators. A waiting result stalls a last word
// behind it and the words after it; other words keep flowing. Reset clears the
// accumulators and both valid flags.
// ----------------------------------------------------------------------------
module king_robust_pair_counter
    import krpc_pkg::*;
#(
    parameter int WORD_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 word_valid,
    output logic                 word_ready,
    input  logic [ITEM_BITS-1:0] i_low_plane,
    input  logic [ITEM_BITS-1:0] i_high_plane,
    input  logic [ITEM_BITS-1:0] j_low_plane,
    input  logic [ITEM_BITS-1:0] j_high_plane,
    input  logic                 last_word,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [ACC_W-1:0]     valid_loci,
    output logic [ACC_W-1:0]     opposite_homozygous,
    output logic [ACC_W-1:0]     distance_sum,
    output logic [ACC_W-1:0]     i_heterozygous,
    output logic [ACC_W-1:0]     j_heterozygous
);

    // Loci actually carried by a word
    localparam int LOCI = (WORD_BITS < ITEM_BITS) ? WORD_BITS : ITEM_BITS;

    logic [ITEM_BITS-1:0] locus_mask;
    logic                 word_accept;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_last_reg,  s1_last_next;
    logic                 s1_advance;
    logic                 result_busy;
    merge_ctl_t           ctl;
    lane_cnt_t            lane_cnt [NUM_LANES];

    // Positions above the word width are not loci
    always_comb
    begin
        for (int b = 0; b < ITEM_BITS; b++)
        begin
            locus_mask[b] = (b < LOCI);
        end
    end

    // Stage handshake: a last word waits for the result slot
    assign s1_advance  = ~s1_last_reg | ~result_busy;
    assign word_ready  = ~s1_valid_reg | s1_advance;
    assign word_accept = word_valid & word_ready;
    assign ctl.fire    = s1_valid_reg & s1_advance;
    assign ctl.last    = s1_last_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_last_next  = s1_last_reg;
        if (word_accept)
        begin
            s1_valid_next = 1'b1;
            s1_last_next  = last_word;
        end
        else if (ctl.fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_last_reg  <= s1_last_next;
        end
    end

    // Counting lanes
    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        krpc_lane u_lane
        (
            .clk    (clk),
            .load   (word_accept),
            .i_low  (i_low_plane[l*LANE_BITS +: LANE_BITS]),
            .i_high (i_high_plane[l*LANE_BITS +: LANE_BITS]),
            .j_low  (j_low_plane[l*LANE_BITS +: LANE_BITS]),
            .j_high (j_high_plane[l*LANE_BITS +: LANE_BITS]),
            .mask   (locus_mask[l*LANE_BITS +: LANE_BITS]),
            .cnt    (lane_cnt[l])
        );
    end

    // Merge and accumulate
    krpc_merge u_merge
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .lane_cnt            (lane_cnt),
        .ctl                 (ctl),
        .result_ready        (result_ready),
        .result_valid        (result_valid),
        .result_busy         (result_busy),
        .valid_loci          (valid_loci),
        .opposite_homozygous (opposite_homozygous),
        .distance_sum        (distance_sum),
        .i_heterozygous      (i_heterozygous),
        .j_heterozygous      (j_heterozygous)
    );

    // A new result only follows a last word leaving the lane stage
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(ctl.fire && ctl.last))
        else $error("result raised without a last word");

    // A held last word behind a waiting result blocks new requests
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg && result_busy) |-> !word_ready)
        else $error("request taken while last word stalled");

    // An accepted request always occupies the lane stage next cycle
    a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        word_accept |=> s1_valid_reg)
        else $error("accepted request lost from lane stage");

endmodule

FILE: tb/krpc_pair_totals_checker.sv
// ----------------------------------------------------------------------------
// krpc_pair_totals_checker
// Watches both channels of the pair counter. It keeps its own running totals
// for the open pair and queues the totals that each last word should give.
// Every result request is compared field by field with the oldest queued
// totals. The number of faults and of totals still awaited go to the bench.
// ----------------------------------------------------------------------------
module krpc_pair_totals_checker
    import krpc_pkg::*;
#(
    parameter int WORD_BITS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 word_valid,
    input  logic                 word_ready,
    input  logic [ITEM_BITS-1:0] i_low_plane,
    input  logic [ITEM_BITS-1:0] i_high_plane,
    input  logic [ITEM_BITS-1:0] j_low_plane,
    input  logic [ITEM_BITS-1:0] j_high_plane,
    input  logic                 last_word,
    input  logic                 result_valid,
    input  logic                 result_ready,
    input  logic [ACC_W-1:0]     valid_loci,
    input  logic [ACC_W-1:0]     opposite_homozygous,
    input  logic [ACC_W-1:0]     distance_sum,
    input  logic [ACC_W-1:0]     i_heterozygous,
    input  logic [ACC_W-1:0]     j_heterozygous,
    output int unsigned          fault_count,
    output int unsigned          pending_totals
);

    // Positions above WORD_BITS carry no locus
    localparam logic [ITEM_BITS-1:0] LOCUS_MASK =
        (WORD_BITS >= ITEM_BITS) ? '1 : ((ITEM_BITS'(1) << WORD_BITS) - 1);

    typedef struct packed {
        logic [ACC_W-1:0] loci;
        logic [ACC_W-1:0] ibs0;
        logic [ACC_W-1:0] dist_sum;
        logic [ACC_W-1:0] i_het;
        logic [ACC_W-1:0] j_het;
    } pair_totals_t;

    pair_totals_t     awaited_totals_q[$];
    // Running counts of the open pair, wrapping at 2^32
    logic [ACC_W-1:0] run_loci  = '0;
    logic [ACC_W-1:0] run_ibs0  = '0;
    logic [ACC_W-1:0] run_het   = '0;
    logic [ACC_W-1:0] run_i_het = '0;
    logic [ACC_W-1:0] run_j_het = '0;
    int unsigned      faults    = 0;

    task automatic check_field(input string field, input logic [ACC_W-1:0] want,
                               input logic [ACC_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            faults++;
        end
    endtask

    // Sample both channels at the edge; results are taken before words so a
    // result can never match the word accepted at the same edge
    always @(posedge clk)
    begin : watch_channels
        logic [ITEM_BITS-1:0] present;
        logic [ITEM_BITS-1:0] lo_diff;
        logic [ITEM_BITS-1:0] hi_diff;
        logic [ACC_W-1:0]     nxt_loci;
        logic [ACC_W-1:0]     nxt_ibs0;
        logic [ACC_W-1:0]     nxt_het;
        logic [ACC_W-1:0]     nxt_i_het;
        logic [ACC_W-1:0]     nxt_j_het;
        pair_totals_t         want;

        if (!rst_n)
        begin
            run_loci  = '0;
            run_ibs0  = '0;
            run_het   = '0;
            run_i_het = '0;
            run_j_het = '0;
            awaited_totals_q.delete();
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (awaited_totals_q.size() == 0)
                begin
                    $error("result request with no totals awaited: valid_loci %0d",
                           valid_loci);
                    faults++;
                end
                else
                begin
                    want = awaited_totals_q.pop_front();
                    check_field("valid_loci", want.loci, valid_loci);
                    check_field("opposite_homozygous", want.ibs0, opposite_homozygous);
                    check_field("distance_sum", want.dist_sum, distance_sum);
                    check_field("i_heterozygous", want.i_het, i_heterozygous);
                    check_field("j_heterozygous", want.j_het, j_heterozygous);
                end
            end

            if (word_valid && word_ready)
            begin
                // A locus counts only if neither genotype is the missing code
                present = (i_low_plane | ~i_high_plane) & (j_low_plane | ~j_high_plane)
                          & LOCUS_MASK;
                lo_diff = i_low_plane ^ j_low_plane;
                hi_diff = i_high_plane ^ j_high_plane;

                nxt_loci  = run_loci  + ACC_W'($countones(present));
                nxt_ibs0  = run_ibs0  + ACC_W'($countones(lo_diff & hi_diff & present));
                nxt_het   = run_het   + ACC_W'($countones((lo_diff ^ hi_diff) & present));
                nxt_i_het = run_i_het + ACC_W'($countones(i_low_plane & ~i_high_plane
                                                          & present));
                nxt_j_het = run_j_het + ACC_W'($countones(j_low_plane & ~j_high_plane
                                                          & present));

                if (last_word)
                begin
                    want.loci     = nxt_loci;
                    want.ibs0     = nxt_ibs0;
                    want.dist_sum = nxt_het + (nxt_ibs0 << 2);
                    want.i_het    = nxt_i_het;
                    want.j_het    = nxt_j_het;
                    awaited_totals_q.push_back(want);
                    run_loci  = '0;
                    run_ibs0  = '0;
                    run_het   = '0;
                    run_i_het = '0;
                    run_j_het = '0;
                end
                else
                begin
                    run_loci  = nxt_loci;
                    run_ibs0  = nxt_ibs0;
                    run_het   = nxt_het;
                    run_i_het = nxt_i_het;
                    run_j_het = nxt_j_het;
                end
            end
        end

        fault_count    <= faults;
        pending_totals <= awaited_totals_q.size();
    end

endmodule

FILE: tb/tb_king_robust_pair_counter.sv
// ----------------------------------------------------------------------------
// tb_king_robust_pair_counter
// Drives genotype word requests into the pair counter and accepts its totals.
// A directed set covers uniform genotype pairs, missing loci, padded tails
// and single-word pairs; a long receiver hold-off fills the block; then
// random pairs with random gaps on both sides, ending with a calm stretch.
// Checking is done by the checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_king_robust_pair_counter;
    import krpc_pkg::*;

    localparam int WORD_BITS        = 64;
    localparam int RESET_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 250;
    localparam int STALL_LIMIT      = 2000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_WORDS     = 850;
    localparam int CALM_WORDS       = 60;

    // Genotype codes, low + 2*high
    localparam logic [1:0] GT_HOM_REF = 2'd0;
    localparam logic [1:0] GT_HET     = 2'd1;
    localparam logic [1:0] GT_MISSING = 2'd2;
    localparam logic [1:0] GT_HOM_ALT = 2'd3;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 word_valid   = 1'b0;
    logic [ITEM_BITS-1:0] i_low_plane  = '0;
    logic [ITEM_BITS-1:0] i_high_plane = '0;
    logic [ITEM_BITS-1:0] j_low_plane  = '0;
    logic [ITEM_BITS-1:0] j_high_plane = '0;
    logic                 last_word    = 1'b0;
    logic                 result_ready = 1'b0;
    logic                 word_ready;
    logic                 result_valid;
    logic [ACC_W-1:0]     valid_loci;
    logic [ACC_W-1:0]     opposite_homozygous;
    logic [ACC_W-1:0]     distance_sum;
    logic [ACC_W-1:0]     i_heterozygous;
    logic [ACC_W-1:0]     j_heterozygous;
    int unsigned          fault_count;
    int unsigned          pending_totals;

    bit                   tx_bursts    = 1'b1;
    bit                   rx_bursts    = 1'b1;
    int                   holds_asked  = 0;
    int                   holds_done   = 0;
    int unsigned          quiet_cycles = 0;

    king_robust_pair_counter #(.WORD_BITS(WORD_BITS)) dut (.*);

    krpc_pair_totals_checker #(.WORD_BITS(WORD_BITS)) totals_checker (.*);

    always #5 clk = ~clk;

    // Offer one word request, sometimes after a random gap, and hold it until taken
    task automatic send_word(input logic [ITEM_BITS-1:0] il, input logic [ITEM_BITS-1:0] ih,
                             input logic [ITEM_BITS-1:0] jl, input logic [ITEM_BITS-1:0] jh,
                             input logic last);
        if (tx_bursts && $urandom_range(0, 3) == 0)
        begin
            word_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        word_valid   <= 1'b1;
        i_low_plane  <= il;
        i_high_plane <= ih;
        j_low_plane  <= jl;
        j_high_plane <= jh;
        last_word    <= last;
        @(posedge clk);
        while (!word_ready) @(posedge clk);
    endtask

    // Same genotype at every locus for each individual
    task automatic send_uniform(input logic [1:0] gi, input logic [1:0] gj, input logic last);
        send_word({ITEM_BITS{gi[0]}}, {ITEM_BITS{gi[1]}},
                  {ITEM_BITS{gj[0]}}, {ITEM_BITS{gj[1]}}, last);
    endtask

    function automatic logic [1:0] pick_genotype(input int miss_pct);
        if ($urandom_range(0, 99) < miss_pct)
            return GT_MISSING;
        case ($urandom_range(0, 2))
            0:       return GT_HOM_REF;
            1:       return GT_HET;
            default: return GT_HOM_ALT;
        endcase
    endfunction

    // Random genotypes on the low loci_used loci, missing code above them
    task automatic send_genotypes(input int miss_pct, input int loci_used, input bit twin,
                                  input logic last);
        logic [ITEM_BITS-1:0] il;
        logic [ITEM_BITS-1:0] ih;
        logic [ITEM_BITS-1:0] jl;
        logic [ITEM_BITS-1:0] jh;
        for (int k = 0; k < ITEM_BITS; k++)
        begin
            {ih[k], il[k]} = (k < loci_used) ? pick_genotype(miss_pct) : GT_MISSING;
            if (twin)
                {jh[k], jl[k]} = {ih[k], il[k]};
            else
                {jh[k], jl[k]} = (k < loci_used) ? pick_genotype(miss_pct) : GT_MISSING;
        end
        send_word(il, ih, jl, jh, last);
    endtask

    // Mostly well-formed pairs of a few words, some raw noise
    task automatic send_random_word();
        logic last;
        last = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 9))
            0: send_word({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom}, last);
            1: send_genotypes($urandom_range(0, 30), $urandom_range(1, ITEM_BITS - 1),
                              1'b0, last | ($urandom_range(0, 3) != 0));
            2: send_genotypes($urandom_range(0, 30), ITEM_BITS, 1'b1, last);
            default: send_genotypes($urandom_range(0, 40), ITEM_BITS, 1'b0, last);
        endcase
    endtask

    // Sender pause: nothing offered until every awaited total has come back
    task automatic wait_for_totals();
        word_valid <= 1'b0;
        @(posedge clk);
        while (pending_totals != 0) @(posedge clk);
    endtask

    // Result side: ready stretches, random stall bursts, and long hold-offs
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (holds_asked != holds_done)
            begin
                holds_done   = holds_done + 1;
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_bursts && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Watchdog on cycles with no request accepted on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((word_valid && word_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("tb_king_robust_pair_counter: errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus and verdict
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Uniform pairs: all valid, opposite homozygotes, one-plane differences
        send_uniform(GT_HOM_REF, GT_HOM_REF, 1'b1);
        send_uniform(GT_HOM_REF, GT_HOM_ALT, 1'b0);
        send_uniform(GT_HET, GT_HOM_REF, 1'b0);
        send_uniform(GT_HOM_ALT, GT_HET, 1'b0);
        send_uniform(GT_HET, GT_HET, 1'b1);
        send_uniform(GT_HOM_ALT, GT_HOM_ALT, 1'b1);
        // Missing on one side or both: nothing counted
        send_uniform(GT_MISSING, GT_HOM_REF, 1'b1);
        send_uniform(GT_HOM_ALT, GT_MISSING, 1'b1);
        send_uniform(GT_MISSING, GT_MISSING, 1'b1);
        send_uniform(GT_HET, GT_MISSING, 1'b0);
        // Alternating planes and the end loci
        send_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                  64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
        send_word(64'h8000_0000_0000_0001, '0, '0, '0, 1'b0);
        send_word('1, '0, '0, '1, 1'b1);
        // Padded tail words closing a pair
        send_genotypes(0, 20, 1'b0, 1'b1);
        send_genotypes(0, 1, 1'b0, 1'b1);
        send_genotypes(10, ITEM_BITS - 1, 1'b0, 1'b1);
        // One longer pair of several words
        repeat (6) send_genotypes(10, ITEM_BITS, 1'b0, 1'b0);
        send_genotypes(10, 37, 1'b0, 1'b1);

        // Receiver holds off while last words keep coming, so the block stalls
        tx_bursts   = 1'b0;
        holds_asked = holds_asked + 1;
        while (holds_done != holds_asked) @(posedge clk);
        repeat (16) send_genotypes($urandom_range(0, 20), ITEM_BITS, 1'b0,
                                   $urandom_range(0, 3) != 0);
        wait_for_totals();
        tx_bursts = 1'b1;

        repeat (RANDOM_WORDS) send_random_word();

        // Calm stretch at the end, no gaps on either side
        tx_bursts = 1'b0;
        rx_bursts = 1'b0;
        repeat (CALM_WORDS) send_random_word();
        send_genotypes(10, ITEM_BITS, 1'b0, 1'b1);

        wait_for_totals();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && pending_totals == 0)
            $display("tb_king_robust_pair_counter: clean");
        else
            $display("tb_king_robust_pair_counter: errors");
        $finish;
    end

endmodule
